FILE: rtl/assert_macros.svh
// Assertion helpers for the checker module msa_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define MSA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MSA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/msa_pkg.sv
package msa_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LANES    = 4;

  localparam int WINDOW_LENGTH        = 100;
  localparam int LOAD_CURRENT_BLOCK   = 60;
  localparam int SUPPLY_CURRENT_BLOCK = 30;
  localparam int SUPPLY_VOLTAGE_BLOCK = 100;
  localparam int RESISTANCE_BLOCK     = 30;

  // lane order: load current, supply current, supply voltage, resistance
  localparam int BLOCK_LEN [LANES] = '{LOAD_CURRENT_BLOCK, SUPPLY_CURRENT_BLOCK,
                                       SUPPLY_VOLTAGE_BLOCK, RESISTANCE_BLOCK};

  localparam int IN_W       = (LANES + 1) * SAMPLE_W;
  localparam int OUT_DATA_W = (LANES + 1) * SAMPLE_W;
  localparam int OUT_USER_W = LANES;

  // sliding window, divide by reciprocal multiply (exact for the sum range)
  localparam int WIN_POS_W   = $clog2(WINDOW_LENGTH);
  localparam int WIN_SUM_W   = SAMPLE_W + $clog2(WINDOW_LENGTH);
  localparam int WIN_SHIFT   = WIN_SUM_W + $clog2(WINDOW_LENGTH);
  localparam int WIN_RECIP_W = WIN_SUM_W + 1;
  localparam int WIN_PROD_W  = WIN_SUM_W + WIN_RECIP_W;
  localparam logic [WIN_POS_W-1:0] WIN_LAST = WIN_POS_W'(WINDOW_LENGTH - 1);
  localparam logic [WIN_RECIP_W-1:0] WIN_RECIP =
    WIN_RECIP_W'(((64'd1 << WIN_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic take;  // item accepted into stage 1
    logic adv2;  // valid item moves stage 1 -> 2
    logic adv3;  // valid item moves stage 2 -> 3
  } pipe_ctl_t;

endpackage

FILE: rtl/multichannel_sample_averager_top.sv
// Throughput: one item per cycle while the output is not stalled by out_tready;
// stages are: ring read and block accumulate, window sum and block reciprocal multiply,
// window multiply and hold, output register.
// Backpressure stalls the stages behind the output register; empty stages still fill.
// Reset (rst_n low, synchronous) clears window valid bits, sums, counts and held averages.
module multichannel_sample_averager_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // lv, load current, supply current, supply voltage, resistance samples
  input  logic [msa_pkg::IN_W-1:0]          in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // lv avg, load current, supply current, supply voltage, resistance avgs
  output logic [msa_pkg::OUT_DATA_W-1:0]    out_tdata,
  // fresh: load current, supply current, supply voltage, resistance
  output logic [msa_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready
);

  msa_pkg::pipe_ctl_t                              ctl;
  logic                                            v1_r;
  logic                                            v2_r;
  logic                                            v3_r;
  logic                                            v4_r;
  logic                                            en1;
  logic                                            en2;
  logic                                            en3;
  logic                                            en4;
  logic [msa_pkg::LANES-1:0][msa_pkg::SAMPLE_W-1:0] samples;
  logic [msa_pkg::LANES-1:0][msa_pkg::SAMPLE_W-1:0] blk_avg;
  logic [msa_pkg::LANES-1:0]                       blk_fresh;
  msa_pkg::sample_t                                win_avg;
  logic [msa_pkg::OUT_DATA_W-1:0]                  data_r;
  logic [msa_pkg::OUT_USER_W-1:0]                  user_r;

  assign en4 = !v4_r || out_tready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign ctl.take = in_tvalid && en1;
  assign ctl.adv2 = v1_r && en2;
  assign ctl.adv3 = v2_r && en3;

  always_comb begin
    for (int i = 0; i < msa_pkg::LANES; i++) begin
      samples[i] = in_tdata[(i + 1) * msa_pkg::SAMPLE_W +: msa_pkg::SAMPLE_W];
    end
  end

  msa_window_lane u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_tdata[msa_pkg::SAMPLE_W-1:0]),
    .avg    (win_avg)
  );

  msa_block_bank u_blocks (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .samples (samples),
    .avg     (blk_avg),
    .fresh   (blk_fresh)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // merge lanes into the output item
  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      data_r <= {blk_avg, win_avg};
      user_r <= blk_fresh;
    end
  end

  assign in_tready  = en1;
  assign out_tvalid = v4_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

FILE: rtl/msa_window_lane.sv
module msa_window_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  msa_pkg::pipe_ctl_t ctl,
  input  msa_pkg::sample_t   sample,
  output msa_pkg::sample_t   avg
);

  msa_pkg::sample_t                     mem [msa_pkg::WINDOW_LENGTH];
  logic [msa_pkg::WINDOW_LENGTH-1:0]    valid_r;
  logic [msa_pkg::WIN_POS_W-1:0]        pos_r;
  logic [msa_pkg::WIN_POS_W-1:0]        pos_nxt;
  msa_pkg::sample_t                     old_r;
  msa_pkg::sample_t                     new_r;
  logic [msa_pkg::WIN_SUM_W-1:0]        sum_r;
  logic [msa_pkg::WIN_SUM_W-1:0]        sum_nxt;
  logic [msa_pkg::WIN_PROD_W-1:0]       prod_r;

  assign pos_nxt = (pos_r == msa_pkg::WIN_LAST) ? '0 : pos_r + 1'b1;
  assign sum_nxt = sum_r - msa_pkg::WIN_SUM_W'(old_r) + msa_pkg::WIN_SUM_W'(new_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      pos_r   <= '0;
      sum_r   <= '0;
    end else begin
      if (ctl.take) begin
        valid_r[pos_r] <= 1'b1;
        pos_r          <= pos_nxt;
      end
      if (ctl.adv2) begin
        sum_r <= sum_nxt;
      end
    end
  end

  // ring store: read old slot and overwrite it in the same cycle
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      mem[pos_r] <= sample;
      new_r      <= sample;
      old_r      <= valid_r[pos_r] ? mem[pos_r] : '0;
    end
    if (ctl.adv3) begin
      prod_r <= sum_r * msa_pkg::WIN_RECIP;
    end
  end

  assign avg = prod_r[msa_pkg::WIN_SHIFT +: msa_pkg::SAMPLE_W];

endmodule

FILE: rtl/msa_block_bank.sv
module msa_block_bank (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  msa_pkg::pipe_ctl_t                            ctl,
  input  logic [msa_pkg::LANES-1:0][msa_pkg::SAMPLE_W-1:0] samples,
  output logic [msa_pkg::LANES-1:0][msa_pkg::SAMPLE_W-1:0] avg,
  output logic [msa_pkg::LANES-1:0]                     fresh
);

  for (genvar g = 0; g < msa_pkg::LANES; g++) begin : g_lane
    localparam int LEN     = msa_pkg::BLOCK_LEN[g];
    localparam int CNT_W   = $clog2(LEN + 1);
    localparam int SUM_W   = msa_pkg::SAMPLE_W + $clog2(LEN);
    localparam int SHIFT   = SUM_W + $clog2(LEN);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(LEN) - 64'd1) / 64'(LEN));
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(LEN);

    logic [SUM_W-1:0]  acc_r;
    logic [SUM_W-1:0]  acc_nxt;
    logic [CNT_W-1:0]  cnt_r;
    logic [CNT_W-1:0]  cnt_nxt;
    logic              wrap;
    logic [SUM_W-1:0]  tot_r;
    logic              done1_r;
    logic [PROD_W-1:0] prod_r;
    logic              done2_r;
    msa_pkg::sample_t  held_r;
    logic              done3_r;

    assign acc_nxt = acc_r + SUM_W'(samples[g]);
    assign cnt_nxt = cnt_r + 1'b1;
    assign wrap    = (cnt_nxt == CNT_END);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        acc_r   <= '0;
        cnt_r   <= '0;
        done1_r <= 1'b0;
        done2_r <= 1'b0;
        done3_r <= 1'b0;
        held_r  <= '0;
      end else begin
        if (ctl.take) begin
          acc_r   <= wrap ? '0 : acc_nxt;
          cnt_r   <= wrap ? '0 : cnt_nxt;
          done1_r <= wrap;
        end
        if (ctl.adv2) begin
          done2_r <= done1_r;
        end
        if (ctl.adv3) begin
          done3_r <= done2_r;
          if (done2_r) begin
            held_r <= prod_r[SHIFT +: msa_pkg::SAMPLE_W];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.take) begin
        tot_r <= acc_nxt;
      end
      if (ctl.adv2) begin
        prod_r <= tot_r * RECIP;
      end
    end

    assign avg[g]   = held_r;
    assign fresh[g] = done3_r;
  end

endmodule

FILE: rtl/msa_checker.sv
`include "assert_macros.svh"

module msa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic [msa_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [msa_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready
);

  logic                                               out_stall;
  logic [msa_pkg::OUT_USER_W+msa_pkg::OUT_DATA_W-1:0] out_item;

  assign out_stall = out_tvalid && !out_tready;
  assign out_item  = {out_tuser, out_tdata};

  `MSA_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_tvalid && $stable(out_item), "held item changed")
  `MSA_ASSERT_ALWAYS(a_reset_empty, clk, $rose(rst_n) |-> !out_tvalid, "valid right after reset")
  `MSA_ASSERT(a_ready_when_empty, clk, rst_n, !out_tvalid |-> in_tready, "input stalled while empty")
  `MSA_ASSERT(a_equal_blocks, clk, rst_n, out_tvalid |-> out_tuser[1] == out_tuser[3], "equal blocks apart")
  `MSA_ASSERT(a_nested_blocks, clk, rst_n, out_tvalid && out_tuser[0] |-> out_tuser[1], "nested blocks apart")

endmodule

bind multichannel_sample_averager_top msa_checker u_msa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
